@@ rtl/osv_pkg.sv @@
// Shared constants and types for the octahedron sphere vertex unit.
package osv_pkg;
	localparam int LOD_W    = 7;
	localparam int RAD_W    = 16;
	localparam int GRID_W   = 6;
	localparam int POS_W    = 25;
	localparam int MAX_LOD  = 64;
	localparam int FRAC_SH  = 7;     // UNIT_FRAC_BITS - 8
	localparam int Q_BITS   = 24;    // quotient bits of the divide-by-root unit
	localparam int X_W      = 29;    // numerator width
	localparam int N_W      = 14;    // norm width
	localparam int ACC_W    = 68;    // trial accumulator width
	localparam int DSR_LAT  = Q_BITS + 1;
	localparam int LATENCY  = DSR_LAT + 5;
	localparam int HUE_W    = 20;
	localparam int HUE_ONE  = 262144;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;

	typedef struct packed {
		logic       off;
		logic       pole;
		logic [1:0] side;
		logic       lower;
		logic       xneg;
		logic       yneg;
	} side_t;
endpackage

@@ rtl/octahedron_sphere_vertex_unit.sv @@
// The done strobe follows an accepted start through the stage registers and the divide-by-root units.
// Throughput: one vertex per cycle; busy is never raised, the pipeline has no stall.
// Depth is set by the divide-by-root units: an entry stage, then 24 stages of one quotient bit each.
// Reset clears valid bits and sets level_of_detail = 2, sphere_radius = 256.
// Results cannot be held off by the receiver.
module octahedron_sphere_vertex_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         face_number,
	input  logic [osv_pkg::GRID_W-1:0]         grid_column,
	input  logic [osv_pkg::GRID_W-1:0]         grid_row,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [osv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [osv_pkg::RAD_W-1:0]          cfg_data,
	output logic                               done,
	output logic signed [osv_pkg::POS_W-1:0]   pos_x,
	output logic signed [osv_pkg::POS_W-1:0]   pos_y,
	output logic signed [osv_pkg::POS_W-1:0]   pos_z,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic                               out_of_face
);
	localparam int DL = osv_pkg::DSR_LAT;
	localparam int PW = osv_pkg::POS_W;
	localparam int HW = osv_pkg::HUE_W;

	logic [osv_pkg::LOD_W-1:0] lod_q;
	logic [osv_pkg::RAD_W-1:0] rad_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_q <= 7'd2;
			rad_q <= 16'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				osv_pkg::REG_LOD:    lod_q <= cfg_data[osv_pkg::LOD_W-1:0];
				osv_pkg::REG_RADIUS: rad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: clamp detail, split the face, find a
	logic [osv_pkg::LOD_W-1:0] lod_c;
	logic [7:0]                sum_c;
	always_comb begin
		lod_c = lod_q;
		if (lod_q < 7'd2) lod_c = 7'd2;
		if (lod_q > 7'(osv_pkg::MAX_LOD)) lod_c = 7'(osv_pkg::MAX_LOD);
		sum_c = 8'(grid_column) + 8'(grid_row);
	end

	logic        v_s1, off_s1, lower_s1;
	logic [1:0]  side_s1;
	logic [5:0]  a_s1, i_s1, j_s1;
	logic [15:0] rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		off_s1   <= sum_c > 8'(lod_c - 7'd1);
		a_s1     <= 6'(8'(lod_c - 7'd1) - sum_c);
		i_s1     <= grid_column;
		j_s1     <= grid_row;
		side_s1  <= face_number[1:0];
		lower_s1 <= face_number[2];
		rad_s1   <= rad_q;
	end

	// stage 2: products, norms and rotated direction
	logic signed [7:0] dx_c, dy_c;
	always_comb begin
		unique case (side_s1)
			2'd0:    begin dx_c =  8'(a_s1); dy_c =  8'(i_s1); end
			2'd1:    begin dx_c = -8'(i_s1); dy_c =  8'(a_s1); end
			2'd2:    begin dx_c = -8'(a_s1); dy_c = -8'(i_s1); end
			default: begin dx_c =  8'(i_s1); dy_c = -8'(a_s1); end
		endcase
		if (lower_s1) dy_c = -dy_c;
	end

	logic                         v_s2;
	osv_pkg::side_t               sb_s2;
	logic [osv_pkg::X_W-1:0]      xa_s2, xb_s2, xc_s2, xh_s2;
	logic [osv_pkg::N_W-1:0]      n_s2, nh_s2;
	logic [6:0]                   ady_c;

	assign ady_c = dy_c[7] ? 7'(-dy_c) : 7'(dy_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		xa_s2 <= (osv_pkg::X_W'(rad_s1) * osv_pkg::X_W'(a_s1)) << osv_pkg::FRAC_SH;
		xb_s2 <= (osv_pkg::X_W'(rad_s1) * osv_pkg::X_W'(i_s1)) << osv_pkg::FRAC_SH;
		xc_s2 <= (osv_pkg::X_W'(rad_s1) * osv_pkg::X_W'(j_s1)) << osv_pkg::FRAC_SH;
		xh_s2 <= osv_pkg::X_W'({ady_c, 16'd0});
		n_s2  <= osv_pkg::N_W'(a_s1) * osv_pkg::N_W'(a_s1)
		         + osv_pkg::N_W'(i_s1) * osv_pkg::N_W'(i_s1)
		         + osv_pkg::N_W'(j_s1) * osv_pkg::N_W'(j_s1);
		nh_s2 <= osv_pkg::N_W'(dx_c) * osv_pkg::N_W'(dx_c)
		         + osv_pkg::N_W'(dy_c) * osv_pkg::N_W'(dy_c);
		sb_s2.off   <= off_s1;
		sb_s2.pole  <= (a_s1 == 6'd0) && (i_s1 == 6'd0);
		sb_s2.side  <= side_s1;
		sb_s2.lower <= lower_s1;
		sb_s2.xneg  <= dx_c[7];
		sb_s2.yneg  <= dy_c[7];
	end

	logic [osv_pkg::Q_BITS-1:0] ma, mb, mc, th;
	logic                       dv;

	osv_dsr u_dsr_a (.clk, .arst_n, .in_valid(v_s2), .x(xa_s2), .n(n_s2),
		.out_valid(dv), .q(ma));
	osv_dsr u_dsr_b (.clk, .arst_n, .in_valid(v_s2), .x(xb_s2), .n(n_s2),
		.out_valid(), .q(mb));
	osv_dsr u_dsr_c (.clk, .arst_n, .in_valid(v_s2), .x(xc_s2), .n(n_s2),
		.out_valid(), .q(mc));
	osv_dsr u_dsr_h (.clk, .arst_n, .in_valid(v_s2), .x(xh_s2), .n(nh_s2),
		.out_valid(), .q(th));

	// sideband delay alongside the root units
	osv_pkg::side_t sb_d [0:DL-1];
	always_ff @(posedge clk) begin
		sb_d[0] <= sb_s2;
		for (int s = 1; s < DL; s++) sb_d[s] <= sb_d[s-1];
	end

	// stage 3: signs and hue fold
	osv_pkg::side_t    sb;
	logic signed [PW-1:0] ea, eb, ec, px_c, py_c, pz_c;
	logic signed [HW-1:0] t_c, h_c;
	assign sb = sb_d[DL-1];
	assign ea = PW'(ma);
	assign eb = PW'(mb);
	assign ec = PW'(mc);

	always_comb begin
		unique case (sb.side)
			2'd0:    begin px_c =  ea; py_c =  eb; end
			2'd1:    begin px_c = -eb; py_c =  ea; end
			2'd2:    begin px_c = -ea; py_c = -eb; end
			default: begin px_c =  eb; py_c = -ea; end
		endcase
		pz_c = ec;
		if (sb.lower) begin
			py_c = -py_c;
			pz_c = -pz_c;
		end
		t_c = sb.yneg ? -HW'(th) : HW'(th);
		if (sb.pole)      h_c = '0;
		else if (sb.xneg) h_c = HW'(osv_pkg::HUE_ONE / 2) - t_c;
		else if (sb.yneg) h_c = HW'(osv_pkg::HUE_ONE) + t_c;
		else              h_c = t_c;
	end

	logic                 v_s3, off_s3;
	logic signed [PW-1:0] px_s3, py_s3, pz_s3;
	logic [HW-1:0]        h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= dv;
	end

	always_ff @(posedge clk) begin
		off_s3 <= sb.off;
		px_s3  <= px_c;
		py_s3  <= py_c;
		pz_s3  <= pz_c;
		h_s3   <= h_c;
	end

	// stage 4: per-channel hexcone level
	function automatic logic [18:0] chan_level(input logic [HW-1:0] h, input int kk);
		logic [23:0] u;
		logic [23:0] p;
		begin
			u = 24'(h) * 24'd6 + 24'(kk * osv_pkg::HUE_ONE);
			if (u >= 24'(12 * osv_pkg::HUE_ONE))     u = u - 24'(12 * osv_pkg::HUE_ONE);
			else if (u >= 24'(6 * osv_pkg::HUE_ONE)) u = u - 24'(6 * osv_pkg::HUE_ONE);
			if (u >= 24'(3 * osv_pkg::HUE_ONE)) p = u - 24'(3 * osv_pkg::HUE_ONE);
			else                                  p = 24'(3 * osv_pkg::HUE_ONE) - u;
			if (p <= 24'(osv_pkg::HUE_ONE))            p = '0;
			else                                       p = p - 24'(osv_pkg::HUE_ONE);
			if (p > 24'(osv_pkg::HUE_ONE))             p = 24'(osv_pkg::HUE_ONE);
			chan_level = p[18:0];
		end
	endfunction

	logic                 v_s4, off_s4;
	logic signed [PW-1:0] px_s4, py_s4, pz_s4;
	logic [18:0]          cr_s4, cg_s4, cb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		off_s4 <= off_s3;
		px_s4  <= px_s3;
		py_s4  <= py_s3;
		pz_s4  <= pz_s3;
		cr_s4  <= chan_level(h_s3, 6);
		cg_s4  <= chan_level(h_s3, 4);
		cb_s4  <= chan_level(h_s3, 2);
	end

	// stage 5: scale to 8 bits, zero off-face beats
	function automatic logic [7:0] to_byte(input logic [18:0] c);
		logic [26:0] m;
		begin
			m = 27'(c) * 27'd255 + 27'd131072;
			to_byte = m[25:18];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s4;
	end

	always_ff @(posedge clk) begin
		out_of_face <= off_s4;
		pos_x <= off_s4 ? '0 : px_s4;
		pos_y <= off_s4 ? '0 : py_s4;
		pos_z <= off_s4 ? '0 : pz_s4;
		red   <= off_s4 ? '0 : to_byte(cr_s4);
		green <= off_s4 ? '0 : to_byte(cg_s4);
		blue  <= off_s4 ? '0 : to_byte(cb_s4);
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(osv_pkg::LATENCY) done)
		else $error("accepted beat did not complete on time");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_face |-> pos_x == 0 && pos_z == 0 && red == 0 && blue == 0)
		else $error("off-face beat carries nonzero data");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, osv_pkg::LATENCY))
		else $error("result without a matching start");
endmodule

@@ rtl/osv_dsr.sv @@
// Pipelined round(x / sqrt(n)): one quotient bit per stage.
module osv_dsr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [osv_pkg::X_W-1:0]       x,
	input  logic [osv_pkg::N_W-1:0]       n,
	output logic                          out_valid,
	output logic [osv_pkg::Q_BITS-1:0]    q
);
	localparam int QB = osv_pkg::Q_BITS;
	localparam int AW = osv_pkg::ACC_W;

	logic                 v_s   [0:QB];
	logic signed [AW-1:0] lim_s [0:QB];
	logic signed [AW-1:0] e_s   [0:QB];
	logic signed [AW-1:0] f_s   [0:QB];
	logic signed [AW-1:0] n_s   [0:QB];
	logic [QB-1:0]        q_s   [0:QB];

	// entry stage: square the numerator, seed d = -1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lim_s[0] <= (AW'(x) * AW'(x)) <<< 2;
		e_s[0]   <= AW'(n);
		f_s[0]   <= -AW'(n);
		n_s[0]   <= AW'(n);
		q_s[0]   <= '0;
	end

	for (genvar s = 0; s < QB; s++) begin : g_stage
		localparam int K = QB - 1 - s;
		logic signed [AW-1:0] trial;
		logic                 take;

		assign trial = e_s[s] + (f_s[s] <<< (K + 2)) + (n_s[s] <<< (2 * K + 2));
		assign take  = (trial <= lim_s[s]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else begin
				v_s[s+1] <= v_s[s];
			end
		end

		always_ff @(posedge clk) begin
			lim_s[s+1] <= lim_s[s];
			n_s[s+1]   <= n_s[s];
			if (take) begin
				q_s[s+1] <= q_s[s] | (QB'(1) << K);
				e_s[s+1] <= trial;
				f_s[s+1] <= f_s[s] + (n_s[s] <<< (K + 1));
			end else begin
				q_s[s+1] <= q_s[s];
				e_s[s+1] <= e_s[s];
				f_s[s+1] <= f_s[s];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign q         = q_s[QB];
endmodule
